### rtl/mutf8_to_utf8_transcoder_defines.svh
// assertion macros for the modified-utf-8 to utf-8 transcoder
`ifndef MUTF8_TO_UTF8_TRANSCODER_DEFINES_SVH
`define MUTF8_TO_UTF8_TRANSCODER_DEFINES_SVH

// same-cycle implication
`define MUTF8_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MUTF8_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/mutf8_pkg.sv
// shared constants, types and utf-8 encoder for the transcoder
package mutf8_pkg;

  localparam int unsigned MAX_RESULTS = 6;
  localparam int unsigned CNT_W       = 3;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [15:0] REPL_CP      = 16'hFFFD;
  localparam logic [5:0]  HIGH_SUR_TAG = 6'b110110;
  localparam logic [5:0]  LOW_SUR_TAG  = 6'b110111;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  localparam logic [7:0] LEAD2_MARK = 8'hC0;
  localparam logic [7:0] LEAD3_MARK = 8'hE0;
  localparam logic [7:0] LEAD4_MARK = 8'hF0;
  localparam logic [7:0] CONT_MARK  = 8'h80;

  // utf-8 of u+fffd, first byte at index 0
  localparam logic [2:0][7:0] REPL_UTF8 = {8'hBD, 8'hBF, 8'hEF};

  typedef struct packed {
    logic [CNT_W-1:0] len;
    logic [3:0][7:0]  bytes;
  } enc_t;

  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [CNT_W-1:0]            cnt;
    logic                        last;
    logic                        err;
  } bundle_t;

  function automatic enc_t enc_cp(input logic [20:0] cp);
    enc_t e;
    e.bytes = '0;
    if (cp < 21'h80) begin
      e.len      = 3'd1;
      e.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h800) begin
      e.len      = 3'd2;
      e.bytes[0] = LEAD2_MARK | {3'b000, cp[10:6]};
      e.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
    end else if (cp < 21'h10000) begin
      e.len      = 3'd3;
      e.bytes[0] = LEAD3_MARK | {4'b0000, cp[15:12]};
      e.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
      e.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
    end else begin
      e.len      = 3'd4;
      e.bytes[0] = LEAD4_MARK | {5'b00000, cp[20:18]};
      e.bytes[1] = CONT_MARK | {2'b00, cp[17:12]};
      e.bytes[2] = CONT_MARK | {2'b00, cp[11:6]};
      e.bytes[3] = CONT_MARK | {2'b00, cp[5:0]};
    end
    return e;
  endfunction

endpackage

### rtl/mutf8_ifs.sv
// valid/ready channel interfaces for the transcoder input and output
interface mutf8_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface mutf8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       error;

  modport source (output valid, output out_byte, output last, output error, input ready);
  modport sink (input valid, input out_byte, input last, input error, output ready);
endinterface

### rtl/mutf8_to_utf8_transcoder.sv
// Modified-UTF-8 to UTF-8 transcoder. Each input transaction is either one string byte or an
// end-of-string marker; the decoder turns it into zero to six output bytes in the same cycle and
// loads them into an output byte register, which sends one byte per cycle while the output is
// ready. Output starts in the cycle after the input is taken. A transaction that yields at
// most one byte lets the next one enter in the following cycle, so ASCII streams at one byte
// per clock; one that yields more holds the input off while the output register drains, and
// output stalls stall the input in the same way. Every string ends in one byte with last set:
// a NUL, or a zero byte with error set when the string was malformed, in which case all earlier
// output bytes of that string must be discarded.
`include "mutf8_to_utf8_transcoder_defines.svh"

module mutf8_to_utf8_transcoder import mutf8_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mutf8_in_if.sink   in_i,
  mutf8_out_if.source out_o
);

  logic    in_fire, out_fire, drain_done;
  bundle_t dec_bundle;

  logic [MAX_RESULTS-1:0][7:0] bytes_q;
  logic [CNT_W-1:0]            cnt_q;
  logic                        last_q;
  logic                        err_q;

  mutf8_dec u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_fire),
    .kind_i      (in_i.kind),
    .data_byte_i (in_i.data_byte),
    .bundle_o    (dec_bundle)
  );

  assign out_fire   = out_o.valid && out_o.ready;
  assign drain_done = out_fire && (cnt_q == 3'd1);
  assign in_i.ready = (cnt_q == 3'd0) || drain_done;
  assign in_fire    = in_i.valid && in_i.ready;

  assign out_o.valid    = (cnt_q != 3'd0);
  assign out_o.out_byte = bytes_q[0];
  assign out_o.last     = last_q && (cnt_q == 3'd1);
  assign out_o.error    = err_q && (cnt_q == 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      last_q <= 1'b0;
      err_q  <= 1'b0;
    end else if (in_fire) begin
      cnt_q  <= dec_bundle.cnt;
      last_q <= dec_bundle.last;
      err_q  <= dec_bundle.err;
    end else if (out_fire) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      bytes_q <= dec_bundle.bytes;
    end else if (out_fire) begin
      bytes_q <= {8'h00, bytes_q[MAX_RESULTS-1:1]};
    end
  end

  // end of string always produces at least the closing byte
  `MUTF8_ASSERT_NEXT(a_end_gives_output, clk_i, rst_ni, in_fire && (in_i.kind == KIND_END), out_o.valid, "end transaction produced no output")
  // closing byte is always zero
  `MUTF8_ASSERT_IMP(a_last_is_zero, clk_i, rst_ni, out_o.valid && out_o.last, out_o.out_byte == 8'h00, "closing byte not zero")
  // error only on the closing byte
  `MUTF8_ASSERT_IMP(a_err_on_last, clk_i, rst_ni, out_o.valid && out_o.error, out_o.last, "error flag without last")
  // input held off while more than one byte is queued
  `MUTF8_ASSERT_IMP(a_hold_while_draining, clk_i, rst_ni, cnt_q > 3'd1, !in_i.ready, "input accepted while output bytes pending")

endmodule

### rtl/mutf8_dec.sv
// decoder state and per-transaction result bundle builder
module mutf8_dec import mutf8_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       kind_i,
  input  logic [7:0] data_byte_i,
  output bundle_t    bundle_o
);

  logic [1:0]  bse_q, bse_d;
  logic [15:0] pcp_q, pcp_d;
  logic        hsw_q, hsw_d;
  logic [9:0]  hsb_q, hsb_d;
  logic        failed_q, failed_d;

  logic [15:0] raw_cp, cp_fix;
  logic        is_hi, is_lo;
  logic [20:0] pair_cp, main_cp;
  logic        run_cp, main_on, prefix, nul_on, nul_err;
  enc_t        main_enc;
  logic [CNT_W-1:0] main_len;
  logic [3:0][7:0]  main_bytes;

  assign raw_cp  = (bse_q != 2'd0) ? {pcp_q[9:0], data_byte_i[5:0]} : {8'h00, data_byte_i};
  assign cp_fix  = (raw_cp == 16'h0000) ? REPL_CP : raw_cp;
  assign is_hi   = (cp_fix[15:10] == HIGH_SUR_TAG);
  assign is_lo   = (cp_fix[15:10] == LOW_SUR_TAG);
  assign pair_cp = SUPP_BASE + {1'b0, hsb_q, cp_fix[9:0]};

  always_comb begin
    bse_d    = bse_q;
    pcp_d    = pcp_q;
    hsw_d    = hsw_q;
    hsb_d    = hsb_q;
    failed_d = failed_q;
    run_cp   = 1'b0;
    main_on  = 1'b0;
    main_cp  = '0;
    prefix   = 1'b0;
    nul_on   = 1'b0;
    nul_err  = 1'b0;

    if (kind_i == KIND_END) begin
      nul_on = 1'b1;
      if (failed_q || (bse_q != 2'd0)) begin
        nul_err = 1'b1;
      end else begin
        prefix = hsw_q;
      end
      bse_d    = '0;
      pcp_d    = '0;
      hsw_d    = 1'b0;
      hsb_d    = '0;
      failed_d = 1'b0;
    end else if (!failed_q) begin
      if (bse_q != 2'd0) begin
        if (data_byte_i[7:6] != 2'b10) begin
          failed_d = 1'b1;
        end else begin
          pcp_d = raw_cp;
          bse_d = bse_q - 2'd1;
          if (bse_q == 2'd1) begin
            pcp_d  = '0;
            run_cp = 1'b1;
          end
        end
      end else if (!data_byte_i[7]) begin
        run_cp = 1'b1;
      end else if (data_byte_i[7:5] == 3'b110) begin
        pcp_d = {11'b0, data_byte_i[4:0]};
        bse_d = 2'd1;
      end else if (data_byte_i[7:4] == 4'b1110) begin
        pcp_d = {12'b0, data_byte_i[3:0]};
        bse_d = 2'd2;
      end else begin
        failed_d = 1'b1;
      end
    end

    if (run_cp) begin
      if (hsw_q && is_lo) begin
        hsw_d   = 1'b0;
        hsb_d   = '0;
        main_on = 1'b1;
        main_cp = pair_cp;
      end else begin
        if (hsw_q) begin
          prefix = 1'b1;
          hsw_d  = 1'b0;
          hsb_d  = '0;
        end
        if (is_hi) begin
          hsw_d = 1'b1;
          hsb_d = cp_fix[9:0];
        end else if (is_lo) begin
          main_on = 1'b1;
          main_cp = {5'b0, REPL_CP};
        end else begin
          main_on = 1'b1;
          main_cp = {5'b0, cp_fix};
        end
      end
    end
  end

  assign main_enc   = enc_cp(main_cp);
  assign main_len   = main_on ? main_enc.len : (nul_on ? 3'd1 : 3'd0);
  assign main_bytes = main_on ? main_enc.bytes : '0;

  always_comb begin
    bundle_o.bytes = '0;
    if (prefix) begin
      for (int i = 0; i < 3; i++) begin
        bundle_o.bytes[i]     = REPL_UTF8[i];
        bundle_o.bytes[3 + i] = main_bytes[i];
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        bundle_o.bytes[i] = main_bytes[i];
      end
    end
    bundle_o.cnt  = (prefix ? 3'd3 : 3'd0) + main_len;
    bundle_o.last = nul_on;
    bundle_o.err  = nul_err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bse_q    <= '0;
      pcp_q    <= '0;
      hsw_q    <= 1'b0;
      hsb_q    <= '0;
      failed_q <= 1'b0;
    end else if (accept_i) begin
      bse_q    <= bse_d;
      pcp_q    <= pcp_d;
      hsw_q    <= hsw_d;
      hsb_q    <= hsb_d;
      failed_q <= failed_d;
    end
  end

endmodule
